// File: sv/six_square_metal_voice_assert.svh
// Assertion macros for the metallic voice block and its checker.
`ifndef SIX_SQUARE_METAL_VOICE_ASSERT_SVH
`define SIX_SQUARE_METAL_VOICE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSMV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("six_square_metal_voice: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSMV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("six_square_metal_voice: next-cycle check failed");

`endif

// File: sv/ssmv_pkg.sv
package ssmv_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_ADV,
    ST_FILT,
    ST_DIV,
    ST_CORR,
    ST_OUT1,
    ST_OUT2,
    ST_OUT3,
    ST_ENV
  } state_t;

  typedef enum logic [1:0] {
    CFG_BASE_STEP,
    CFG_SPREAD,
    CFG_DECAY,
    CFG_GAIN
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int BASE_W     = 24;
  localparam int SPREAD_W   = 16;
  localparam int DECAY_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int ENV_W      = 17;
  localparam int HP_W       = 18;
  localparam int RATIO_W    = 15;
  localparam int RIDX_W     = 3;
  localparam int SCALE_W    = 17;
  localparam int Q14        = 14;

  // shared multiplier
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // filter and constant divide
  localparam int T_W         = 23;
  localparam int TMAG_W      = 22;
  localparam int TP_W        = 38;
  localparam int X_W         = TP_W - 16;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 24;
  localparam int Q_W         = 23;
  localparam int R_W         = 27;

  localparam int OUT_SHIFT = 31;
  localparam int YMAG_W    = MUL_P_W - OUT_SHIFT;

  localparam logic [MUL_P_W-1:0] HALF_Q14  = MUL_P_W'(8192);
  localparam logic [MUL_P_W-1:0] HALF_ENV  = MUL_P_W'(32768);
  localparam logic [MUL_P_W-1:0] HALF_OUT  = MUL_P_W'(64'd1 << (OUT_SHIFT - 1));
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(16384);
  localparam logic [15:0]        HP_COEF   = 16'd60948;
  localparam logic [ENV_W-1:0]   ENV_ONE   = ENV_W'(65536);

  localparam logic signed [HP_W-1:0] HP_MAX = 18'sd131071;
  localparam logic signed [HP_W-1:0] HP_MIN = -18'sd131072;
  localparam logic [Q_W-1:0] HP_POS_LIM = Q_W'(131071);
  localparam logic [Q_W-1:0] HP_NEG_LIM = Q_W'(131072);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic [YMAG_W-1:0] YMAG_POS_LIM = YMAG_W'(32767);
  localparam logic [YMAG_W-1:0] YMAG_NEG_LIM = YMAG_W'(32768);

  localparam logic [BASE_W-1:0]   BASE_STEP_RST = '0;
  localparam logic [SPREAD_W-1:0] SPREAD_RST    = 16'd16384;
  localparam logic [DECAY_W-1:0]  DECAY_RST     = 16'd65000;
  localparam logic [GAIN_W-1:0]   GAIN_RST      = 16'd29491;

  // inharmonic ratios less one, Q1.14; spare slots run at ratio 1.0
  function automatic logic [RATIO_W-1:0] ratio_less_one(input logic [RIDX_W-1:0] idx);
    logic [RATIO_W-1:0] r;
    unique case (idx)
      3'd0:    r = 15'd0;
      3'd1:    r = 15'd7325;
      3'd2:    r = 15'd10109;
      3'd3:    r = 15'd15180;
      3'd4:    r = 15'd24622;
      3'd5:    r = 15'd27258;
      3'd6:    r = 15'd0;
      3'd7:    r = 15'd0;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/ssmv_mul.sv
module ssmv_mul (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ssmv_pkg::MUL_A_W-1:0]     a,
  input  logic [ssmv_pkg::MUL_B_W-1:0]     b,
  output logic [ssmv_pkg::MUL_P_W-1:0]     p
);

  logic [ssmv_pkg::MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ssmv_pkg::MUL_P_W'(a) * ssmv_pkg::MUL_P_W'(b);
    end
  end

  assign p = p_r;

endmodule

// File: sv/six_square_metal_voice.sv
// Metallic hi-hat voice: each request on the in_ channel yields one signed Q1.15 sample on
// the out_ channel. Six square oscillators at fixed inharmonic ratios of base_step are
// averaged, high-passed, shaped by a decaying envelope and the gain, and saturated; a request
// with start_req set restarts phases, filter and envelope before its sample. All of a request is
// paced by the one shared 35x24 multiplier: two products per oscillator, then one each for
// the filter, the divide by NUM_OSC, the envelope scaling, the gain and the envelope decay.
// in_ready is high only while the sequencer is idle. The sample sits in an output register,
// so the next request is taken while it waits; if it is still unclaimed when the next sample
// is due, the sequencer holds. cfg_ready is always high; write the registers (0 base_step,
// 1 spread, 2 decay_factor, 3 gain) only while no request is in flight.
module six_square_metal_voice #(
  parameter int NUM_OSC    = 6,
  parameter int PHASE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_start_req,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ssmv_pkg::SAMPLE_W-1:0]   out_sample,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ssmv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssmv_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int OSC_IDX_W   = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int SUM_W       = $clog2(NUM_OSC + 1) + 1;
  localparam int DIFF_W      = SUM_W + 1;
  localparam int STEP_FULL_W = ssmv_pkg::BASE_W + ssmv_pkg::SCALE_W - ssmv_pkg::Q14;
  localparam int STEP_EXT_W  = (PHASE_BITS > STEP_FULL_W) ? PHASE_BITS : STEP_FULL_W;

  localparam logic [ssmv_pkg::RECIP_W-1:0] RECIP =
    ssmv_pkg::RECIP_W'((64'd1 << ssmv_pkg::RECIP_SHIFT) / NUM_OSC);
  localparam logic [ssmv_pkg::TP_W+1:0] DIV_BIAS = (ssmv_pkg::TP_W+2)'(NUM_OSC) << 15;
  localparam logic [OSC_IDX_W-1:0] LAST_OSC = OSC_IDX_W'(NUM_OSC - 1);
  localparam logic [ssmv_pkg::R_W-1:0] N_R = ssmv_pkg::R_W'(NUM_OSC);
  localparam logic signed [ssmv_pkg::T_W-1:0] N_T = ssmv_pkg::T_W'(NUM_OSC);

  // configuration
  logic [ssmv_pkg::BASE_W-1:0]   base_step_r;
  logic [ssmv_pkg::SPREAD_W-1:0] spread_r;
  logic [ssmv_pkg::DECAY_W-1:0]  decay_r;
  logic [ssmv_pkg::GAIN_W-1:0]   gain_r;

  // sequencer and voice state
  ssmv_pkg::state_t state_r, state_nxt;
  logic [OSC_IDX_W-1:0]            k_r, k_nxt;
  logic [PHASE_BITS-1:0]           phase_r [NUM_OSC];
  logic [PHASE_BITS-1:0]           phase_nxt [NUM_OSC];
  logic signed [SUM_W-1:0]         sum_r, sum_nxt;
  logic signed [SUM_W-1:0]         prev_r, prev_nxt;
  logic signed [ssmv_pkg::HP_W-1:0] hp_r, hp_nxt;
  logic [ssmv_pkg::ENV_W-1:0]      env_r, env_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            t_neg_r, t_neg_nxt;
  logic [ssmv_pkg::X_W-1:0]        x_r, x_nxt;
  logic signed [ssmv_pkg::SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  // shared multiplier
  logic                          mul_en;
  logic [ssmv_pkg::MUL_A_W-1:0]  mul_a;
  logic [ssmv_pkg::MUL_B_W-1:0]  mul_b;
  logic [ssmv_pkg::MUL_P_W-1:0]  mul_p;

  // datapath terms
  logic                          in_fire, out_fire, out_free;
  logic [ssmv_pkg::RIDX_W-1:0]   ratio_idx;
  logic [ssmv_pkg::MUL_P_W-1:0]  round_q14;
  logic [ssmv_pkg::SCALE_W-1:0]  scale;
  logic [STEP_FULL_W-1:0]        step_full;
  logic [STEP_EXT_W-1:0]         step_ext;
  logic [PHASE_BITS-1:0]         phase_new;
  logic                          vote;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [ssmv_pkg::T_W-1:0] t_val;
  logic [ssmv_pkg::TMAG_W-1:0]   t_mag;
  logic [ssmv_pkg::TP_W+1:0]     x_sum;
  logic [ssmv_pkg::Q_W-1:0]      q0, q;
  logic [ssmv_pkg::R_W-1:0]      rem;
  logic [ssmv_pkg::HP_W-1:0]     hp_mag;
  logic [ssmv_pkg::MUL_P_W-1:0]  y_sum, env_sum;
  logic [ssmv_pkg::YMAG_W-1:0]   y_mag;

  assign in_ready   = (state_r == ssmv_pkg::ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid_r && out_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r <= ssmv_pkg::BASE_STEP_RST;
      spread_r    <= ssmv_pkg::SPREAD_RST;
      decay_r     <= ssmv_pkg::DECAY_RST;
      gain_r      <= ssmv_pkg::GAIN_RST;
    end else if (cfg_valid) begin
      unique case (ssmv_pkg::cfg_idx_t'(cfg_index))
        ssmv_pkg::CFG_BASE_STEP: base_step_r <= cfg_wdata[ssmv_pkg::BASE_W-1:0];
        ssmv_pkg::CFG_SPREAD:    spread_r    <= cfg_wdata[ssmv_pkg::SPREAD_W-1:0];
        ssmv_pkg::CFG_DECAY:     decay_r     <= cfg_wdata[ssmv_pkg::DECAY_W-1:0];
        ssmv_pkg::CFG_GAIN:      gain_r      <= cfg_wdata[ssmv_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ssmv_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // oscillator terms; the ratio product for the next oscillator is issued while advancing
  assign ratio_idx = (state_r == ssmv_pkg::ST_ADV)
                   ? ssmv_pkg::RIDX_W'(k_r) + ssmv_pkg::RIDX_W'(1)
                   : ssmv_pkg::RIDX_W'(k_r);
  assign round_q14 = mul_p + ssmv_pkg::HALF_Q14;
  assign scale     = ssmv_pkg::SCALE_ONE
                   + round_q14[ssmv_pkg::Q14 +: ssmv_pkg::SCALE_W];
  assign step_full = round_q14[ssmv_pkg::Q14 +: STEP_FULL_W];
  assign step_ext  = STEP_EXT_W'(step_full);
  assign phase_new = phase_r[k_r] + step_ext[PHASE_BITS-1:0];
  assign vote      = (phase_new != '0) && !phase_new[PHASE_BITS-1];

  // high-pass terms
  assign diff  = DIFF_W'(sum_r) - DIFF_W'(prev_r);
  assign t_val = (ssmv_pkg::T_W'(hp_r) * N_T) + (ssmv_pkg::T_W'(diff) <<< 15);
  assign t_mag = t_val[ssmv_pkg::T_W-1] ? ssmv_pkg::TMAG_W'(-t_val)
                                        : ssmv_pkg::TMAG_W'(t_val);
  assign x_sum = (ssmv_pkg::TP_W+2)'(mul_p[ssmv_pkg::TP_W-1:0]) + DIV_BIAS;

  // reciprocal quotient is at most one short: one compare settles it
  assign q0  = mul_p[ssmv_pkg::RECIP_SHIFT +: ssmv_pkg::Q_W];
  assign rem = ssmv_pkg::R_W'(x_r) - ssmv_pkg::R_W'(q0) * N_R;
  assign q   = q0 + ssmv_pkg::Q_W'(rem >= N_R);

  // output terms
  assign hp_mag  = ssmv_pkg::HP_W'(hp_r[ssmv_pkg::HP_W-1] ? -hp_r : hp_r);
  assign y_sum   = mul_p + ssmv_pkg::HALF_OUT;
  assign y_mag   = y_sum[ssmv_pkg::MUL_P_W-1:ssmv_pkg::OUT_SHIFT];
  assign env_sum = mul_p + ssmv_pkg::HALF_ENV;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssmv_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = ssmv_pkg::ST_STEP;
      end
      ssmv_pkg::ST_STEP: state_nxt = ssmv_pkg::ST_ADV;
      ssmv_pkg::ST_ADV: begin
        state_nxt = (k_r == LAST_OSC) ? ssmv_pkg::ST_FILT : ssmv_pkg::ST_STEP;
      end
      ssmv_pkg::ST_FILT: state_nxt = ssmv_pkg::ST_DIV;
      ssmv_pkg::ST_DIV:  state_nxt = ssmv_pkg::ST_CORR;
      ssmv_pkg::ST_CORR: state_nxt = ssmv_pkg::ST_OUT1;
      ssmv_pkg::ST_OUT1: state_nxt = ssmv_pkg::ST_OUT2;
      ssmv_pkg::ST_OUT2: state_nxt = ssmv_pkg::ST_OUT3;
      ssmv_pkg::ST_OUT3: begin
        // hold until the output register is free
        if (out_free) state_nxt = ssmv_pkg::ST_ENV;
      end
      ssmv_pkg::ST_ENV: state_nxt = ssmv_pkg::ST_IDLE;
      default: state_nxt = ssmv_pkg::ST_IDLE;
    endcase
  end

  // datapath and multiplier operands
  always_comb begin
    mul_en         = 1'b1;
    mul_a          = '0;
    mul_b          = '0;
    k_nxt          = k_r;
    phase_nxt      = phase_r;
    sum_nxt        = sum_r;
    prev_nxt       = prev_r;
    hp_nxt         = hp_r;
    env_nxt        = env_r;
    t_neg_nxt      = t_neg_r;
    x_nxt          = x_r;
    out_sample_nxt = out_sample_r;
    out_valid_nxt  = out_fire ? 1'b0 : out_valid_r;
    unique case (state_r)
      ssmv_pkg::ST_IDLE: begin
        mul_a = ssmv_pkg::MUL_A_W'(spread_r);
        mul_b = ssmv_pkg::MUL_B_W'(ssmv_pkg::ratio_less_one(ratio_idx));
        if (in_fire) begin
          k_nxt   = '0;
          sum_nxt = '0;
          if (in_start_req) begin
            for (int i = 0; i < NUM_OSC; i++) phase_nxt[i] = '0;
            prev_nxt = '0;
            hp_nxt   = '0;
            env_nxt  = ssmv_pkg::ENV_ONE;
          end
        end
      end
      ssmv_pkg::ST_STEP: begin
        mul_a = ssmv_pkg::MUL_A_W'(base_step_r);
        mul_b = ssmv_pkg::MUL_B_W'(scale);
      end
      ssmv_pkg::ST_ADV: begin
        mul_a = ssmv_pkg::MUL_A_W'(spread_r);
        mul_b = ssmv_pkg::MUL_B_W'(ssmv_pkg::ratio_less_one(ratio_idx));
        phase_nxt[k_r] = phase_new;
        sum_nxt = vote ? sum_r + SUM_W'(1) : sum_r - SUM_W'(1);
        k_nxt   = (k_r == LAST_OSC) ? '0 : k_r + OSC_IDX_W'(1);
      end
      ssmv_pkg::ST_FILT: begin
        mul_a     = ssmv_pkg::MUL_A_W'(t_mag);
        mul_b     = ssmv_pkg::MUL_B_W'(ssmv_pkg::HP_COEF);
        t_neg_nxt = t_val[ssmv_pkg::T_W-1];
      end
      ssmv_pkg::ST_DIV: begin
        x_nxt = x_sum[ssmv_pkg::TP_W-1:16];
        mul_a = ssmv_pkg::MUL_A_W'(x_sum[ssmv_pkg::TP_W-1:16]);
        mul_b = RECIP;
      end
      ssmv_pkg::ST_CORR: begin
        if (t_neg_r) begin
          hp_nxt = (q > ssmv_pkg::HP_NEG_LIM) ? ssmv_pkg::HP_MIN
                                              : -$signed(ssmv_pkg::HP_W'(q));
        end else begin
          hp_nxt = (q > ssmv_pkg::HP_POS_LIM) ? ssmv_pkg::HP_MAX
                                              : $signed(ssmv_pkg::HP_W'(q));
        end
        prev_nxt = sum_r;
      end
      ssmv_pkg::ST_OUT1: begin
        mul_a = ssmv_pkg::MUL_A_W'(hp_mag);
        mul_b = ssmv_pkg::MUL_B_W'(env_r);
      end
      ssmv_pkg::ST_OUT2: begin
        mul_a = mul_p[ssmv_pkg::MUL_A_W-1:0];
        mul_b = ssmv_pkg::MUL_B_W'(gain_r);
      end
      ssmv_pkg::ST_OUT3: begin
        mul_a  = ssmv_pkg::MUL_A_W'(env_r);
        mul_b  = ssmv_pkg::MUL_B_W'(decay_r);
        // keep the gain product while the output is blocked
        mul_en = out_free;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (hp_r[ssmv_pkg::HP_W-1]) begin
            out_sample_nxt = (y_mag > ssmv_pkg::YMAG_NEG_LIM) ? ssmv_pkg::SAMPLE_MIN
                           : -$signed(ssmv_pkg::SAMPLE_W'(y_mag));
          end else begin
            out_sample_nxt = (y_mag > ssmv_pkg::YMAG_POS_LIM) ? ssmv_pkg::SAMPLE_MAX
                           : $signed(ssmv_pkg::SAMPLE_W'(y_mag));
          end
        end
      end
      ssmv_pkg::ST_ENV: begin
        env_nxt = env_sum[16 +: ssmv_pkg::ENV_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssmv_pkg::ST_IDLE;
      k_r         <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
      hp_r        <= '0;
      env_r       <= ssmv_pkg::ENV_ONE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_OSC; i++) phase_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
      hp_r        <= hp_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_neg_r      <= t_neg_nxt;
    x_r          <= x_nxt;
    out_sample_r <= out_sample_nxt;
  end

endmodule

// File: sv/ssmv_checker.sv
`include "six_square_metal_voice_assert.svh"

module ssmv_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ssmv_pkg::SAMPLE_W-1:0] out_sample
);

  // an accepted request keeps the block busy while it is worked on
  `SSMV_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready ##1 !in_ready)

  // a blocked sample holds
  `SSMV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample))

  // a new sample only appears while a request is still being finished
  `SSMV_ASSERT_IMPL(a_out_in_flight, $rose(out_valid), !in_ready)

  // after a sample is taken, another is shown only mid-request
  `SSMV_ASSERT_NEXT(a_out_taken, out_valid && out_ready, !out_valid || !in_ready)

endmodule

bind six_square_metal_voice ssmv_checker u_ssmv_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int     VOICES        = 6;
  localparam int     PHASE_W       = 24;
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     SETTLE_CYCLES = 30;
  localparam int     RANDOM_ITEMS  = 800;
  localparam int     MAX_REPORTS   = 40;
  localparam longint FILTER_COEF   = 60948;
  localparam longint HP_CEIL       = 131071;
  localparam longint HP_FLOOR      = -131072;
  localparam longint OUT_DEN       = 64'sd2147483648;
  localparam logic [16:0]        ENV_UNITY     = 17'd65536;
  localparam logic [PHASE_W-1:0] HALF_TURN     = 24'h800000;
  localparam logic [10:0]        READY_PATTERN = 11'b10110011101;

  typedef enum logic [1:0] {RECV_FREE, RECV_RANDOM, RECV_PATTERN, RECV_SLOW} recv_mode_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic                                 in_start_req;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [ssmv_pkg::SAMPLE_W-1:0] out_sample;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [ssmv_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [ssmv_pkg::CFG_DATA_W-1:0]      cfg_wdata;

  // predicted voice state and register copies
  logic [PHASE_W-1:0]   osc_phase_q [VOICES];
  int                   last_votes;
  logic signed [17:0]   hp_q;
  logic [16:0]          env_q;
  logic [23:0]          base_step_q;
  logic [15:0]          spread_q;
  logic [15:0]          decay_q;
  logic [15:0]          gain_q;

  logic signed [ssmv_pkg::SAMPLE_W-1:0] expected_samples [$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned starts_sent;
  int unsigned samples_checked;
  int unsigned full_scale_seen;
  int unsigned config_writes;
  int unsigned input_stall_cycles;

  logic        sender_bursty;
  logic        offering;
  int          burst_left;
  recv_mode_t  recv_mode;
  int unsigned recv_tick;
  int unsigned hold_ask;
  int unsigned hold_left;

  six_square_metal_voice dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint osc_ratio(input int k);
    case (k)
      1:       return 7325;
      2:       return 10109;
      3:       return 15180;
      4:       return 24622;
      5:       return 27258;
      default: return 0;
    endcase
  endfunction

  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void clear_voice_state();
    int k;
    for (k = 0; k < VOICES; k++) osc_phase_q[k] = '0;
    last_votes = 0;
    hp_q = '0;
    env_q = ENV_UNITY;
  endfunction

  function automatic logic signed [ssmv_pkg::SAMPLE_W-1:0] predict_voice_sample(
      input logic start);
    longint scale;
    longint step;
    longint t;
    longint hp;
    longint y;
    int     votes;
    int     k;
    if (start) clear_voice_state();
    votes = 0;
    for (k = 0; k < VOICES; k++) begin
      scale = 16384 + ((osc_ratio(k) * longint'(spread_q) + 8192) >> 14);
      step = (longint'(base_step_q) * scale + 8192) >> 14;
      osc_phase_q[k] = osc_phase_q[k] + step[PHASE_W-1:0];
      if (osc_phase_q[k] != '0 && osc_phase_q[k] < HALF_TURN) votes++;
      else votes--;
    end
    t = longint'(hp_q) * VOICES + longint'(votes - last_votes) * 32768;
    hp = round_div(t * FILTER_COEF, VOICES * 65536);
    if (hp > HP_CEIL) hp = HP_CEIL;
    if (hp < HP_FLOOR) hp = HP_FLOOR;
    hp_q = hp[17:0];
    last_votes = votes;
    y = round_div(hp * longint'(env_q) * longint'(gain_q), OUT_DEN);
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    // decay after the sample
    env_q = 17'((longint'(env_q) * longint'(decay_q) + 32768) >> 16);
    return y[ssmv_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_sample(input logic signed [ssmv_pkg::SAMPLE_W-1:0] got);
    logic signed [ssmv_pkg::SAMPLE_W-1:0] want;
    if (expected_samples.size() == 0) begin
      report_mismatch("sample with no request outstanding", got, 0);
    end else begin
      want = expected_samples.pop_front();
      samples_checked++;
      if (want == 16'sh7FFF || want == 16'sh8000) full_scale_seen++;
      if (got !== want) report_mismatch("out_sample", got, want);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && !in_ready) input_stall_cycles++;
    if (rst_n && out_valid && out_ready) check_sample(out_sample);
  end

  // receiver: long hold-offs on request, otherwise its own stall pattern
  always @(posedge clk) begin
    recv_tick <= recv_tick + 1;
    if (hold_ask != 0) begin
      hold_left <= hold_ask;
      hold_ask <= 0;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (recv_mode)
        RECV_FREE:    out_ready <= 1'b1;
        RECV_RANDOM:  out_ready <= ($urandom_range(0, 2) != 0);
        RECV_PATTERN: out_ready <= READY_PATTERN[recv_tick % 11];
        default:      out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout with %0d samples outstanding", expected_samples.size());
    $display("testbench failed");
    $finish;
  end

  task automatic send_voice_request(input logic start);
    logic signed [ssmv_pkg::SAMPLE_W-1:0] predicted;
    in_valid <= 1'b1;
    in_start_req <= start;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = predict_voice_sample(start);
    expected_samples = {expected_samples, predicted};
    requests_sent++;
    if (start) starts_sent++;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        burst_left = $urandom_range(0, 12);
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // drop the request line and hold until every sample is back
  task automatic wait_all_samples();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_voice(input logic [23:0] base, input logic [15:0] spr,
                               input logic [15:0] dec, input logic [15:0] gn,
                               input logic [3:0] pick);
    logic [ssmv_pkg::CFG_DATA_W-1:0] data [4];
    int                              i;
    logic                            wrote;
    // upper byte of the 16-bit registers is junk and must be ignored
    data[ssmv_pkg::CFG_BASE_STEP] = base;
    data[ssmv_pkg::CFG_SPREAD]    = {8'($urandom), spr};
    data[ssmv_pkg::CFG_DECAY]     = {8'($urandom), dec};
    data[ssmv_pkg::CFG_GAIN]      = {8'($urandom), gn};
    wrote = 1'b0;
    for (i = 0; i < 4; i++) begin
      if (pick[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= ssmv_pkg::CFG_IDX_W'(i);
        cfg_wdata <= data[i];
        do @(posedge clk); while (!cfg_ready);
        case (ssmv_pkg::cfg_idx_t'(i))
          ssmv_pkg::CFG_BASE_STEP: base_step_q = data[i];
          ssmv_pkg::CFG_SPREAD:    spread_q = data[i][15:0];
          ssmv_pkg::CFG_DECAY:     decay_q = data[i][15:0];
          ssmv_pkg::CFG_GAIN:      gain_q = data[i][15:0];
          default:                 ;
        endcase
        config_writes++;
        wrote = 1'b1;
      end
    end
    if (wrote) cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_values();
    recv_mode <= RECV_FREE;
    sender_bursty = 1'b0;
    repeat (3) send_voice_request(1'b0);
    wait_all_samples();
  endtask

  task automatic test_extreme_settings();
    // full-scale step, widest spread, slowest decay, gain above unity
    program_voice(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
    send_voice_request(1'b1);
    repeat (3) send_voice_request(1'b0);
    wait_all_samples();
    // half-turn step, no spread, zero decay, unity gain
    recv_mode <= RECV_PATTERN;
    program_voice(HALF_TURN, 16'd0, 16'd0, 16'd32768, 4'hF);
    send_voice_request(1'b1);
    repeat (3) send_voice_request(1'b0);
    wait_all_samples();
  endtask

  task automatic test_restart_mid_voice();
    program_voice(24'd1, 16'd16384, 16'd65000, 16'd0, 4'hF);
    send_voice_request(1'b1);
    send_voice_request(1'b0);
    wait_all_samples();
    recv_mode <= RECV_RANDOM;
    sender_bursty = 1'b1;
    burst_left = 1;
    program_voice(24'h123456, 16'd40000, 16'd60000, 16'd32768, 4'hF);
    send_voice_request(1'b1);
    repeat (3) send_voice_request(1'b0);
    send_voice_request(1'b1);
    repeat (2) send_voice_request(1'b0);
    wait_all_samples();
  endtask

  task automatic test_output_backpressure();
    recv_mode <= RECV_FREE;
    sender_bursty = 1'b0;
    program_voice(24'($urandom), 16'd16384, 16'd64000, 16'd32768, 4'hF);
    // hold the receiver off while requests keep coming
    hold_ask <= 300;
    send_voice_request(1'b1);
    repeat (11) send_voice_request(1'b0);
    wait_all_samples();
  endtask

  task automatic test_random_voices();
    int unsigned      target;
    logic [23:0]      base;
    logic [15:0]      spr;
    logic [15:0]      dec;
    logic [15:0]      gn;
    target = requests_sent + RANDOM_ITEMS;
    while (requests_sent < target) begin
      wait_all_samples();
      case ($urandom_range(0, 5))
        0:       base = '0;
        1:       base = '1;
        2:       base = 24'($urandom_range(1, 20000));
        3:       base = HALF_TURN + 24'($urandom_range(0, 64)) - 24'd32;
        default: base = 24'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       spr = '0;
        1:       spr = '1;
        default: spr = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       dec = '0;
        1:       dec = '1;
        2:       dec = 16'($urandom);
        default: dec = 16'($urandom_range(60000, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       gn = '0;
        1:       gn = 16'd32768;
        2:       gn = '1;
        3:       gn = 16'($urandom_range(32769, 65535));
        default: gn = 16'($urandom_range(1, 32768));
      endcase
      program_voice(base, spr, dec, gn, 4'($urandom_range(1, 15)));
      sender_bursty = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(0, 12);
      recv_mode <= recv_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(1, 3)) begin
        send_voice_request(1'b1);
        repeat ($urandom_range(5, 40)) send_voice_request($urandom_range(0, 39) == 0);
      end
      // stray requests with restarts at random
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(3, 10)) send_voice_request($urandom_range(0, 1) == 1);
    end
    wait_all_samples();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_req = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ssmv_pkg::CFG_BASE_STEP;
    cfg_wdata = '0;
    recv_mode = RECV_FREE;
    recv_tick = 0;
    hold_ask = 0;
    hold_left = 0;
    sender_bursty = 1'b0;
    offering = 1'b0;
    burst_left = 0;
    base_step_q = ssmv_pkg::BASE_STEP_RST;
    spread_q = ssmv_pkg::SPREAD_RST;
    decay_q = ssmv_pkg::DECAY_RST;
    gain_q = ssmv_pkg::GAIN_RST;
    clear_voice_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_extreme_settings();
    test_restart_mid_voice();
    test_output_backpressure();
    test_random_voices();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d requests (%0d restarts) across %0d register writes; %0d samples checked,",
             requests_sent, starts_sent, config_writes, samples_checked);
    $display("%0d at full scale; input back-pressured for %0d cycles; %0d mismatches",
             full_scale_seen, input_stall_cycles, error_count);
    if (error_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
